@@ hdl/ccb_pkg.sv @@
package ccb_pkg;

    // work ram geometry
    localparam int RAM_BYTES  = 2048;
    localparam int RAM_ADDR_W = $clog2(RAM_BYTES);
    localparam int RAM_DATA_W = 8;
    localparam int OAM_BYTES  = 256;
    localparam int OAM_IDX_W  = $clog2(OAM_BYTES);

    // item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // ppu operation codes
    localparam logic [1:0] PPU_NONE  = 2'd0;
    localparam logic [1:0] PPU_WRITE = 2'd1;
    localparam logic [1:0] PPU_READ  = 2'd2;
    localparam logic [1:0] PPU_PEEK  = 2'd3;

    // address map
    localparam logic [15:0] RAM_LAST    = 16'h1FFF;
    localparam logic [15:0] PPU_FIRST   = 16'h2000;
    localparam logic [15:0] PPU_LAST    = 16'h3FFF;
    localparam logic [15:0] DMA_START   = 16'h4014;
    localparam logic [15:0] PAD0_ADDR   = 16'h4016;
    localparam logic [15:0] PAD1_ADDR   = 16'h4017;

    // tick phase
    localparam logic [2:0] PHASE_EVEN_SLOT = 3'd0;
    localparam logic [2:0] PHASE_ODD_SLOT  = 3'd3;
    localparam logic [2:0] PHASE_LAST      = 3'd5;

    // one result beat as held in the output register
    typedef struct packed {
        logic [7:0]  read_data;
        logic        ram_sel;
        logic [1:0]  ppu_op;
        logic [2:0]  ppu_register;
        logic        cpu_step;
        logic        dma_busy;
        logic [15:0] fetch_address;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        cpu_nmi;
    } result_t;

endpackage

@@ hdl/console_cpu_bus_with_oam_dma.sv @@
// CPU bus decoder with sprite-memory DMA. One beat is a CPU write, a CPU read
// or one master tick, and every beat yields exactly one result beat. The block
// takes one beat per clock cycle while the result side keeps up; a beat stalls
// only while the output register holds an untaken result. Results are registered.
// Work RAM is a 2 KB synchronous memory with a registered read: its output
// register feeds read_data directly for the result of a RAM read, and a DMA
// fetch from RAM is copied into the DMA byte register on the following cycle,
// well before the matching sprite-memory write three ticks later. There is no
// clearing pass after reset; reads of RAM bytes never written return anything.
module console_cpu_bus_with_oam_dma (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        peek_only,
    input  logic        cart_hit,
    input  logic [7:0]  cart_data,
    input  logic [7:0]  ppu_read_data,
    input  logic [7:0]  pad0_buttons,
    input  logic [7:0]  pad1_buttons,
    input  logic        ppu_nmi_pending,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [1:0]  ppu_op,
    output logic [2:0]  ppu_register,
    output logic        cpu_step,
    output logic        dma_busy,
    output logic [15:0] fetch_address,
    output logic        oam_write,
    output logic [7:0]  oam_index,
    output logic [7:0]  oam_data,
    output logic        cpu_nmi
);

    // state
    logic [7:0]  pad0_reg, pad0_next;
    logic [7:0]  pad1_reg, pad1_next;
    logic [7:0]  dma_page_reg, dma_page_next;
    logic [ccb_pkg::OAM_IDX_W-1:0] dma_index_reg, dma_index_next;
    logic [7:0]  dma_byte_reg, dma_byte_next;
    logic        dma_byte_pend_reg, dma_byte_pend_next;
    logic        dma_running_reg, dma_running_next;
    logic        dma_align_reg, dma_align_next;
    logic [2:0]  phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    ccb_pkg::result_t out_reg, out_next;

    // ram port signals
    logic                            ram_we;
    logic                            ram_re;
    logic [ccb_pkg::RAM_ADDR_W-1:0]  ram_waddr;
    logic [ccb_pkg::RAM_ADDR_W-1:0]  ram_raddr;
    logic [ccb_pkg::RAM_DATA_W-1:0]  ram_q;

    // decode helpers
    logic        accept;
    logic        do_read;
    logic        dma_fetch;
    logic        peek;
    logic [15:0] rd_addr;
    logic [15:0] dma_addr;
    logic [ccb_pkg::OAM_IDX_W-1:0] index_inc;

    ccb_ram #(
        .WIDTH (ccb_pkg::RAM_DATA_W),
        .DEPTH (ccb_pkg::RAM_BYTES)
    ) u_work_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (write_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign dma_addr  = {dma_page_reg, dma_index_reg};
    assign index_inc = dma_index_reg + 1'b1;

    // dma fetch happens on the even slot once alignment is done
    assign dma_fetch = (mode == ccb_pkg::MODE_TICK) && dma_running_reg && !dma_align_reg
                       && (phase_reg == ccb_pkg::PHASE_EVEN_SLOT);
    assign do_read   = (mode == ccb_pkg::MODE_READ) || dma_fetch;
    assign rd_addr   = dma_fetch ? dma_addr : address;
    assign peek      = (mode == ccb_pkg::MODE_READ) && peek_only;
    assign ram_waddr = address[ccb_pkg::RAM_ADDR_W-1:0];
    assign ram_raddr = rd_addr[ccb_pkg::RAM_ADDR_W-1:0];

    // per-beat decode and state update
    always_comb
    begin
        pad0_next          = pad0_reg;
        pad1_next          = pad1_reg;
        dma_page_next      = dma_page_reg;
        dma_index_next     = dma_index_reg;
        dma_byte_next      = dma_byte_pend_reg ? ram_q : dma_byte_reg;
        dma_byte_pend_next = 1'b0;
        dma_running_next   = dma_running_reg;
        dma_align_next     = dma_align_reg;
        phase_next         = phase_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_next           = out_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;

            // read decode, shared by cpu reads and dma fetches
            if (do_read)
            begin
                out_next.fetch_address = rd_addr;
                if (cart_hit)
                begin
                    out_next.read_data = cart_data;
                end
                else if (rd_addr <= ccb_pkg::RAM_LAST)
                begin
                    ram_re           = 1'b1;
                    out_next.ram_sel = 1'b1;
                end
                else if (rd_addr inside {[ccb_pkg::PPU_FIRST:ccb_pkg::PPU_LAST]})
                begin
                    out_next.read_data    = ppu_read_data;
                    out_next.ppu_op       = peek ? ccb_pkg::PPU_PEEK : ccb_pkg::PPU_READ;
                    out_next.ppu_register = rd_addr[2:0];
                end
                else if (rd_addr == ccb_pkg::PAD0_ADDR)
                begin
                    out_next.read_data = {7'b0, pad0_reg[7]};
                    pad0_next          = {pad0_reg[6:0], 1'b0};
                end
                else if (rd_addr == ccb_pkg::PAD1_ADDR)
                begin
                    out_next.read_data = {7'b0, pad1_reg[7]};
                    pad1_next          = {pad1_reg[6:0], 1'b0};
                end
            end

            case (mode)
                ccb_pkg::MODE_WRITE:
                begin
                    out_next.fetch_address = address;
                    if (!cart_hit)
                    begin
                        if (address <= ccb_pkg::RAM_LAST)
                        begin
                            ram_we = 1'b1;
                        end
                        else if (address inside {[ccb_pkg::PPU_FIRST:ccb_pkg::PPU_LAST]})
                        begin
                            out_next.ppu_op       = ccb_pkg::PPU_WRITE;
                            out_next.ppu_register = address[2:0];
                        end
                        else if (address == ccb_pkg::DMA_START)
                        begin
                            dma_page_next    = write_data;
                            dma_index_next   = '0;
                            dma_running_next = 1'b1;
                        end
                        else if (address == ccb_pkg::PAD0_ADDR)
                        begin
                            pad0_next = pad0_buttons;
                        end
                        else if (address == ccb_pkg::PAD1_ADDR)
                        begin
                            pad1_next = pad1_buttons;
                        end
                    end
                end
                ccb_pkg::MODE_READ:
                begin
                end
                ccb_pkg::MODE_TICK:
                begin
                    out_next.cpu_nmi = ppu_nmi_pending;
                    phase_next = (phase_reg == ccb_pkg::PHASE_LAST) ? '0 : phase_reg + 3'd1;
                    if (phase_reg == ccb_pkg::PHASE_EVEN_SLOT
                        || phase_reg == ccb_pkg::PHASE_ODD_SLOT)
                    begin
                        if (!dma_running_reg)
                        begin
                            out_next.cpu_step = 1'b1;
                        end
                        else if (dma_align_reg)
                        begin
                            if (phase_reg[0])
                            begin
                                dma_align_next = 1'b0;
                            end
                        end
                        else if (dma_fetch)
                        begin
                            // byte comes straight or, from ram, from the memory output register in the next cycle
                            if (out_next.ram_sel)
                            begin
                                dma_byte_pend_next = 1'b1;
                            end
                            else
                            begin
                                dma_byte_next = out_next.read_data;
                            end
                        end
                        else
                        begin
                            out_next.oam_write = 1'b1;
                            out_next.oam_index = dma_index_reg;
                            out_next.oam_data  = dma_byte_reg;
                            dma_index_next     = index_inc;
                            if (index_inc == '0)
                            begin
                                dma_running_next = 1'b0;
                                dma_align_next   = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            out_next.dma_busy = dma_running_next;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad0_reg          <= '0;
            pad1_reg          <= '0;
            dma_page_reg      <= '0;
            dma_index_reg     <= '0;
            dma_byte_reg      <= '0;
            dma_byte_pend_reg <= 1'b0;
            dma_running_reg   <= 1'b0;
            dma_align_reg     <= 1'b1;
            phase_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pad0_reg          <= pad0_next;
            pad1_reg          <= pad1_next;
            dma_page_reg      <= dma_page_next;
            dma_index_reg     <= dma_index_next;
            dma_byte_reg      <= dma_byte_next;
            dma_byte_pend_reg <= dma_byte_pend_next;
            dma_running_reg   <= dma_running_next;
            dma_align_reg     <= dma_align_next;
            phase_reg         <= phase_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // result ports; ram data comes from the memory output register
    assign out_valid     = out_valid_reg;
    assign read_data     = out_reg.ram_sel ? ram_q : out_reg.read_data;
    assign ppu_op        = out_reg.ppu_op;
    assign ppu_register  = out_reg.ppu_register;
    assign cpu_step      = out_reg.cpu_step;
    assign dma_busy      = out_reg.dma_busy;
    assign fetch_address = out_reg.fetch_address;
    assign oam_write     = out_reg.oam_write;
    assign oam_index     = out_reg.oam_index;
    assign oam_data      = out_reg.oam_data;
    assign cpu_nmi       = out_reg.cpu_nmi;

endmodule

@@ hdl/ccb_ram.sv @@
module ccb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ tb/ccb_checker.sv @@
`timescale 1ns / 100ps

module ccb_checker
    import ccb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        peek_only,
    input  logic        cart_hit,
    input  logic [7:0]  cart_data,
    input  logic [7:0]  ppu_read_data,
    input  logic [7:0]  pad0_buttons,
    input  logic [7:0]  pad1_buttons,
    input  logic        ppu_nmi_pending,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_data,
    input  logic [1:0]  ppu_op,
    input  logic [2:0]  ppu_register,
    input  logic        cpu_step,
    input  logic        dma_busy,
    input  logic [15:0] fetch_address,
    input  logic        oam_write,
    input  logic [7:0]  oam_index,
    input  logic [7:0]  oam_data,
    input  logic        cpu_nmi,
    output int          mismatch_count,
    output int          pending_count
);

    // one bus result as seen on the output ports
    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  ppu_op;
        logic [2:0]  ppu_register;
        logic        cpu_step;
        logic        dma_busy;
        logic [15:0] fetch_address;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        cpu_nmi;
    } bus_result_t;

    // shadow of the bus state
    logic [7:0] ram_shadow [RAM_BYTES];
    logic [7:0] pad_sr [2];
    logic [7:0] dma_page;
    logic [7:0] dma_idx;
    logic [7:0] dma_byte;
    logic       dma_on;
    logic       align_wait;
    logic [2:0] phase;

    bus_result_t expected_q [$];
    bus_result_t want;
    bus_result_t got;
    int          beat_no;
    int          reported;

    function automatic string fmt_result(bus_result_t r);
        return $sformatf({"rd=%h op=%0d reg=%0d step=%b busy=%b fa=%h ",
                          "ow=%b oi=%h od=%h nmi=%b"},
                         r.read_data, r.ppu_op, r.ppu_register, r.cpu_step, r.dma_busy,
                         r.fetch_address, r.oam_write, r.oam_index, r.oam_data, r.cpu_nmi);
    endfunction

    // read decode, shared by cpu reads and dma fetches
    task automatic decode_read(input logic [15:0] a, input logic peek,
                               inout bus_result_t r, output logic [7:0] d);
        d = 8'h00;
        if (cart_hit) begin
            d = cart_data;
        end else if (a <= RAM_LAST) begin
            d = ram_shadow[a[RAM_ADDR_W-1:0]];
        end else if (a >= PPU_FIRST && a <= PPU_LAST) begin
            d = ppu_read_data;
            r.ppu_op = peek ? PPU_PEEK : PPU_READ;
            r.ppu_register = a[2:0];
        end else if (a == PAD0_ADDR || a == PAD1_ADDR) begin
            d = {7'd0, pad_sr[a[0]][7]};
            pad_sr[a[0]] = {pad_sr[a[0]][6:0], 1'b0};
        end
    endtask

    // write decode
    task automatic decode_write(input logic [15:0] a, inout bus_result_t r);
        if (cart_hit) begin
            // cartridge owns it, nothing else sees the write
        end else if (a <= RAM_LAST) begin
            ram_shadow[a[RAM_ADDR_W-1:0]] = write_data;
        end else if (a >= PPU_FIRST && a <= PPU_LAST) begin
            r.ppu_op = PPU_WRITE;
            r.ppu_register = a[2:0];
        end else if (a == DMA_START) begin
            // restart keeps the alignment state
            dma_page = write_data;
            dma_idx = 8'h00;
            dma_on = 1'b1;
        end else if (a == PAD0_ADDR || a == PAD1_ADDR) begin
            pad_sr[a[0]] = a[0] ? pad1_buttons : pad0_buttons;
        end
    endtask

    // master tick: cpu slot or dma slot every third tick
    task automatic master_tick(inout bus_result_t r);
        logic [15:0] fa;
        logic [7:0]  d;
        if (phase == PHASE_EVEN_SLOT || phase == PHASE_ODD_SLOT) begin
            if (!dma_on) begin
                r.cpu_step = 1'b1;
            end else if (align_wait) begin
                if (phase[0])
                    align_wait = 1'b0;
            end else if (!phase[0]) begin
                fa = {dma_page, dma_idx};
                r.fetch_address = fa;
                decode_read(fa, 1'b0, r, d);
                dma_byte = d;
                r.read_data = d;
            end else begin
                r.oam_write = 1'b1;
                r.oam_index = dma_idx;
                r.oam_data = dma_byte;
                dma_idx = dma_idx + 8'd1;
                if (dma_idx == 8'h00) begin
                    dma_on = 1'b0;
                    align_wait = 1'b1;
                end
            end
        end
        r.cpu_nmi = ppu_nmi_pending;
        phase = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
    endtask

    task automatic predict_beat(output bus_result_t r);
        logic [7:0] d;
        r = '0;
        case (mode)
            MODE_WRITE: begin
                r.fetch_address = address;
                decode_write(address, r);
            end
            MODE_READ: begin
                r.fetch_address = address;
                decode_read(address, peek_only, r, d);
                r.read_data = d;
            end
            MODE_TICK: master_tick(r);
            default: ;
        endcase
        r.dma_busy = dma_on;
    endtask

    // predict on each input beat, compare each output beat with the oldest
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < RAM_BYTES; i++)
                ram_shadow[i] = 8'h00;
            pad_sr[0] = 8'h00;
            pad_sr[1] = 8'h00;
            dma_page = 8'h00;
            dma_idx = 8'h00;
            dma_byte = 8'h00;
            dma_on = 1'b0;
            align_wait = 1'b1;
            phase = 3'd0;
            expected_q.delete();
            beat_no = 0;
            reported = 0;
            mismatch_count <= 0;
            pending_count <= 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_beat(want);
                expected_q.push_back(want);
            end
            if (out_valid && out_ready) begin
                got = '{read_data, ppu_op, ppu_register, cpu_step, dma_busy, fetch_address,
                        oam_write, oam_index, oam_data, cpu_nmi};
                if (expected_q.size() == 0) begin
                    if (reported < 10)
                        $display("result beat %0d with nothing expected: %s",
                                 beat_no, fmt_result(got));
                    reported++;
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (reported < 10)
                            $display("result beat %0d mismatch\n  expected %s\n  actual   %s",
                                     beat_no, fmt_result(want), fmt_result(got));
                        reported++;
                        mismatch_count <= mismatch_count + 1;
                    end
                end
                beat_no++;
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

@@ tb/tb_console_cpu_bus_with_oam_dma.sv @@
`timescale 1ns / 100ps

module tb_console_cpu_bus_with_oam_dma;
    import ccb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 80;
    localparam int TOTAL_ITEMS  = 1250;
    localparam int PACE_STRETCH = 150;

    typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

    // one bus item as offered on the input side
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        peek_only;
        logic        cart_hit;
        logic [7:0]  cart_data;
        logic [7:0]  ppu_read_data;
        logic [7:0]  pad0;
        logic [7:0]  pad1;
        logic        nmi;
    } bus_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        peek_only;
    logic        cart_hit;
    logic [7:0]  cart_data;
    logic [7:0]  ppu_read_data;
    logic [7:0]  pad0_buttons;
    logic [7:0]  pad1_buttons;
    logic        ppu_nmi_pending;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic [1:0]  ppu_op;
    logic [2:0]  ppu_register;
    logic        cpu_step;
    logic        dma_busy;
    logic [15:0] fetch_address;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        cpu_nmi;

    int mismatch_count;
    int pending_count;
    int cycle_count;

    // pacing and bookkeeping of what ram holds
    int          idle_pct;
    int          stall_pct;
    bit          hold_req;
    int          sent;
    bit          ram_written [RAM_BYTES];
    int unsigned written_idx [$];

    console_cpu_bus_with_oam_dma DUT (.*);

    ccb_checker bus_checker (.*);

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, or a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic bus_item_t rand_fields();
        bus_item_t s;
        s.mode = MODE_TICK;
        s.address = 16'($urandom);
        s.write_data = 8'($urandom);
        s.peek_only = 1'($urandom);
        s.cart_hit = ($urandom_range(0, 7) == 0);
        s.cart_data = 8'($urandom);
        s.ppu_read_data = 8'($urandom);
        s.pad0 = 8'($urandom);
        s.pad1 = 8'($urandom);
        s.nmi = 1'($urandom);
        return s;
    endfunction

    function automatic bit ram_block_full(int blk);
        for (int j = 0; j < 256; j++)
            if (!ram_written[blk * 256 + j])
                return 1'b0;
        return 1'b1;
    endfunction

    // dma source page that never fetches an unwritten ram byte
    function automatic logic [7:0] pick_dma_page();
        logic [7:0] p;
        case ($urandom_range(0, 3))
            0:
            begin
                p = 8'($urandom_range(0, 8'h1F));
                if (!ram_block_full(p[2:0]))
                    p = ram_block_full(0) ? 8'($urandom_range(0, 3) * 8) : 8'h40;
            end
            1: p = 8'($urandom_range(8'h20, 8'h3F));
            2: p = 8'h40;
            default: p = 8'($urandom_range(8'h41, 8'hFF));
        endcase
        return p;
    endfunction

    function automatic bus_item_t make_tick();
        bus_item_t s;
        s = rand_fields();
        s.mode = MODE_TICK;
        return s;
    endfunction

    function automatic bus_item_t make_read();
        bus_item_t s;
        int unsigned idx;
        s = rand_fields();
        s.mode = MODE_READ;
        case ($urandom_range(0, 5))
            0:
            begin
                if (written_idx.size() != 0)
                begin
                    idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
                    s.address = 16'(($urandom_range(0, 3) << 11) | idx);
                end
                else
                begin
                    s.address = 16'($urandom_range(0, RAM_LAST));
                    s.cart_hit = 1'b1;
                end
            end
            1:
            begin
                // cartridge claims a ram address
                s.address = 16'($urandom_range(0, RAM_LAST));
                s.cart_hit = 1'b1;
            end
            2: s.address = 16'($urandom_range(PPU_FIRST, PPU_LAST));
            3: s.address = $urandom_range(0, 1) ? PAD1_ADDR : PAD0_ADDR;
            4: s.address = 16'($urandom_range(16'h4000, 16'hFFFF));
            default: s.address = DMA_START;
        endcase
        return s;
    endfunction

    function automatic bus_item_t make_write(bit allow_dma);
        bus_item_t s;
        s = rand_fields();
        s.mode = MODE_WRITE;
        case ($urandom_range(0, 5))
            0, 1: s.address = 16'($urandom_range(0, RAM_LAST));
            2: s.address = 16'($urandom_range(PPU_FIRST, PPU_LAST));
            3: s.address = $urandom_range(0, 1) ? PAD1_ADDR : PAD0_ADDR;
            4:
            begin
                s.address = 16'($urandom_range(16'h4000, 16'hFFFF));
                if (s.address == DMA_START)
                    s.address = PAD1_ADDR + 16'd1;
            end
            default:
            begin
                if (allow_dma)
                begin
                    s.address = DMA_START;
                    s.write_data = pick_dma_page();
                end
                else
                    s.address = PAD0_ADDR;
            end
        endcase
        return s;
    endfunction

    // offer one beat, wait for it to be taken
    task automatic send_beat(input bus_item_t s);
        int unsigned idx;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        if (s.mode == MODE_WRITE && !s.cart_hit && s.address <= RAM_LAST)
        begin
            idx = s.address[RAM_ADDR_W-1:0];
            if (!ram_written[idx])
            begin
                ram_written[idx] = 1'b1;
                written_idx.push_back(idx);
            end
        end
        mode <= s.mode;
        address <= s.address;
        write_data <= s.write_data;
        peek_only <= s.peek_only;
        cart_hit <= s.cart_hit;
        cart_data <= s.cart_data;
        ppu_read_data <= s.ppu_read_data;
        pad0_buttons <= s.pad0;
        pad1_buttons <= s.pad1;
        ppu_nmi_pending <= s.nmi;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        // rotate the pacing every stretch of beats
        if (sent % PACE_STRETCH == 0)
        begin
            case (pace_t'((sent / PACE_STRETCH) % 4))
                PACE_FULL:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                PACE_SENDER_IDLE:
                begin
                    idle_pct = 55;
                    stall_pct = 0;
                end
                PACE_SINK_STALL:
                begin
                    idle_pct = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
        end
    endtask

    task automatic send_quick(input logic [1:0] m, input logic [15:0] a, input logic [7:0] d,
                              input logic cart, input logic peek);
        bus_item_t s;
        s = rand_fields();
        s.mode = m;
        s.address = a;
        s.write_data = d;
        s.cart_hit = cart;
        s.peek_only = peek;
        send_beat(s);
    endtask

    // stop offering and wait until every expected result has come
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        bus_item_t s;
        int        n;
        bit        held;
        bit        paused;

        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        address = 16'h0000;
        write_data = 8'h00;
        peek_only = 1'b0;
        cart_hit = 1'b0;
        cart_data = 8'h00;
        ppu_read_data = 8'h00;
        pad0_buttons = 8'h00;
        pad1_buttons = 8'h00;
        ppu_nmi_pending = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        sent = 0;
        held = 1'b0;
        paused = 1'b0;
        foreach (ram_written[i])
            ram_written[i] = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: map edges, mirrors, pads, cartridge claim, dma start and restart
        send_quick(MODE_TICK,  16'h0000, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_TICK,  16'hFFFF, 8'hFF, 1'b0, 1'b0);
        send_quick(MODE_WRITE, 16'h0000, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_WRITE, RAM_LAST, 8'hFF, 1'b0, 1'b0);
        send_quick(MODE_READ,  16'h0800, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  16'h07FF, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_WRITE, PPU_FIRST, 8'h5A, 1'b0, 1'b0);
        send_quick(MODE_WRITE, PPU_LAST, 8'hA5, 1'b0, 1'b0);
        send_quick(MODE_READ,  16'h2007, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  16'h3FF8, 8'h00, 1'b0, 1'b1);
        send_quick(MODE_WRITE, PAD0_ADDR, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  PAD0_ADDR, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  PAD0_ADDR, 8'h00, 1'b0, 1'b1);
        send_quick(MODE_WRITE, PAD1_ADDR, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  PAD1_ADDR, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_WRITE, 16'h0005, 8'h77, 1'b1, 1'b0);
        send_quick(MODE_READ,  16'h0005, 8'h00, 1'b1, 1'b0);
        send_quick(MODE_READ,  16'hFFFF, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_READ,  DMA_START, 8'h00, 1'b0, 1'b0);
        send_quick(MODE_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
        send_quick(MODE_WRITE, DMA_START, 8'h20, 1'b0, 1'b0);
        repeat (3) send_beat(make_tick());
        send_quick(MODE_WRITE, DMA_START, 8'hFF, 1'b0, 1'b0);

        // fill one ram block through random mirrors so dma can source from it
        for (int i = 0; i < 256; i++)
        begin
            s = rand_fields();
            s.mode = MODE_WRITE;
            s.cart_hit = 1'b0;
            s.address = 16'(($urandom_range(0, 3) << 11) | i);
            send_beat(s);
        end

        // a transfer from ram driven mostly by ticks
        send_quick(MODE_WRITE, DMA_START, 8'($urandom_range(0, 3) * 8), 1'b0, 1'b0);
        for (int i = 0; i < 400; i++)
        begin
            case ($urandom_range(0, 19))
                0:       send_beat(make_read());
                1:       send_beat(make_write(1'b0));
                default: send_beat(make_tick());
            endcase
        end

        // random sequences
        while (sent < TOTAL_ITEMS)
        begin
            if (!held && sent >= TOTAL_ITEMS - 500)
            begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (!paused && sent >= TOTAL_ITEMS - 300)
            begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // mixed traffic
                    n = $urandom_range(20, 60);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 3))
                            0, 1: send_beat(make_tick());
                            2:    send_beat(make_read());
                            default: send_beat(make_write(1'b0));
                        endcase
                    end
                end
                5, 6:
                begin
                    n = $urandom_range(10, 80);
                    repeat (n) send_beat(make_tick());
                end
                7:
                begin
                    // controller strobe then serial reads
                    s = make_write(1'b0);
                    s.address = $urandom_range(0, 1) ? PAD1_ADDR : PAD0_ADDR;
                    s.cart_hit = ($urandom_range(0, 9) == 0);
                    send_beat(s);
                    repeat (9)
                    begin
                        s = make_read();
                        s.address = $urandom_range(0, 3) ? PAD0_ADDR : PAD1_ADDR;
                        s.cart_hit = ($urandom_range(0, 15) == 0);
                        send_beat(s);
                        if ($urandom_range(0, 3) == 0)
                            send_beat(make_tick());
                    end
                end
                default:
                begin
                    // dma start, possibly restarting a running transfer
                    s = rand_fields();
                    s.mode = MODE_WRITE;
                    s.address = DMA_START;
                    s.write_data = pick_dma_page();
                    s.cart_hit = ($urandom_range(0, 9) == 0);
                    send_beat(s);
                    n = $urandom_range(20, 120);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_beat(make_read());
                        else if ($urandom_range(0, 49) == 0)
                            send_beat(make_write(1'b1));
                        else
                            send_beat(make_tick());
                    end
                end
            endcase
        end

        // drain and let the pipeline settle
        stall_pct = 0;
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ccb_pkg.sv
hdl/ccb_ram.sv
hdl/console_cpu_bus_with_oam_dma.sv
tb/ccb_checker.sv
tb/tb_console_cpu_bus_with_oam_dma.sv
